// ----- hw/rtl/tilt_servo_angle_calibrated_macros.svh -----
// Assertion macros for the tilt servo angle block.
// Included by the RTL modules that carry assertions; no other dependencies.
`ifndef TILT_SERVO_ANGLE_CALIBRATED_MACROS_SVH
`define TILT_SERVO_ANGLE_CALIBRATED_MACROS_SVH
`ifndef SYNTHESIS
// Checked on clk_i, off while rst_ni is low.
`define TSAC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tsac assertion failed");
// Checked on clk_i at every edge, reset included.
`define TSAC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tsac assertion failed");
`else
`define TSAC_ASSERT(lbl, prop)
`define TSAC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- hw/rtl/tsac_pkg.sv -----
// Shared constants, types and the arctangent table for the tilt servo block.
// No dependencies.
package tsac_pkg;

  localparam int CAL_SAMPLES  = 100;
  localparam int ATAN_STAGES  = 16;
  localparam int TABLE_LEN    = 24;
  localparam int QUARTER_TURN = 11520;   // 90 deg in 1/128 deg

  localparam int SUM_W   = 23;
  localparam int CNT_W   = 7;
  localparam int MAG_W   = SUM_W;
  localparam int CORD_W  = 26;           // x/y datapath, covers CORDIC gain
  localparam int ANG_W   = 25;           // angle accumulator, 2^-16 deg
  localparam int ANG_FRAC = 9;           // 2^-16 -> 2^-7 deg
  localparam int RND_W   = ANG_W - ANG_FRAC;
  localparam int OFF_W   = 15;
  localparam int OUT_W   = 17;
  localparam int IDX_W   = 5;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;

  // Truncating divide by CAL_SAMPLES as multiply by a rounded-up reciprocal.
  // Exact while mag * (RECIP*CAL_SAMPLES - 2^RECIP_SH) < 2^RECIP_SH.
  localparam int RECIP_SH = 29;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** RECIP_SH) + CAL_SAMPLES - 1) / CAL_SAMPLES);
  localparam int PROD_W = MAG_W + RECIP_W;

  localparam logic CMD_CAL  = 1'b0;
  localparam logic CMD_MEAS = 1'b1;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [ANG_W-1:0]  ang;
  } lane_t;

  // Special-case override for one angle
  typedef struct packed {
    logic zero;   // numerator zero -> 0
    logic full;   // denominator zero -> +-90 deg
    logic neg;    // numerator sign for the full case
  } frc_t;

  typedef struct packed {
    logic vld;
    logic calfin;
    frc_t roll;
    frc_t pitch;
  } meta_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [ANG_W-1:0] atan_tab(input logic [IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = ANG_W'(2949120);
      5'd1:    v = ANG_W'(1740967);
      5'd2:    v = ANG_W'(919879);
      5'd3:    v = ANG_W'(466945);
      5'd4:    v = ANG_W'(234379);
      5'd5:    v = ANG_W'(117304);
      5'd6:    v = ANG_W'(58666);
      5'd7:    v = ANG_W'(29335);
      5'd8:    v = ANG_W'(14668);
      5'd9:    v = ANG_W'(7334);
      5'd10:   v = ANG_W'(3667);
      5'd11:   v = ANG_W'(1833);
      5'd12:   v = ANG_W'(917);
      5'd13:   v = ANG_W'(458);
      5'd14:   v = ANG_W'(229);
      5'd15:   v = ANG_W'(115);
      5'd16:   v = ANG_W'(57);
      5'd17:   v = ANG_W'(29);
      5'd18:   v = ANG_W'(14);
      5'd19:   v = ANG_W'(7);
      5'd20:   v = ANG_W'(4);
      5'd21:   v = ANG_W'(2);
      5'd22:   v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/tsac_cordic_cell.sv -----
// One CORDIC vectoring iteration on one lane, registered.
// Depends on tsac_pkg (lane_t, atan_tab).
module tsac_cordic_cell (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [tsac_pkg::IDX_W-1:0]   idx_i,   // tied to the cell's position
  input  tsac_pkg::lane_t              lane_i,
  output tsac_pkg::lane_t              lane_o
);

  tsac_pkg::lane_t lane_d, lane_q;
  logic signed [tsac_pkg::CORD_W-1:0] sx, sy;
  logic signed [tsac_pkg::ANG_W-1:0]  tab;

  assign sx  = lane_i.x >>> idx_i;
  assign sy  = lane_i.y >>> idx_i;
  assign tab = tsac_pkg::atan_tab(idx_i);

  always_comb begin
    if (!lane_i.y[tsac_pkg::CORD_W-1]) begin
      lane_d.x   = lane_i.x + sy;
      lane_d.y   = lane_i.y - sx;
      lane_d.ang = lane_i.ang + tab;
    end else begin
      lane_d.x   = lane_i.x - sy;
      lane_d.y   = lane_i.y + sx;
      lane_d.ang = lane_i.ang - tab;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ----- hw/rtl/tsac_front.sv -----
// Calibration accumulator, divide-by-count and CORDIC operand prep.
// Depends on tsac_pkg and tilt_servo_angle_calibrated_macros.svh.
`include "tilt_servo_angle_calibrated_macros.svh"
module tsac_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,     // whole pipe moves
  input  logic                               in_vld_i,  // beat accepted when adv_i
  input  logic                               in_cmd_i,
  input  logic [tsac_pkg::IN_TDATA_W-1:0]    in_data_i,
  output tsac_pkg::lane_t                    roll_o,
  output tsac_pkg::lane_t                    pitch_o,
  output tsac_pkg::meta_t                    meta_o
);

  localparam int SW = tsac_pkg::SUM_W;
  localparam int MW = tsac_pkg::MAG_W;
  localparam int CW = tsac_pkg::CORD_W;
  localparam int AX = 0;
  localparam int AY = 1;
  localparam int AZ = 2;

  logic signed [15:0] acc_x, acc_y, acc_z;
  logic               accept, is_cal, cal_fin;
  logic [tsac_pkg::CNT_W-1:0] cnt_d, cnt_q, cnt_inc;
  logic signed [SW-1:0] sum_x_d, sum_x_q, sum_y_d, sum_y_q, sum_z_d, sum_z_q;
  logic signed [SW-1:0] nsx, nsy, nsz;

  // stage 1: raw values, or the running sums for calibration
  logic              s1_vld_q, s1_cal_q;
  logic signed [SW-1:0] s1_v_q [3];
  // stage 2: sign and magnitude
  logic              s2_vld_q, s2_cal_q;
  logic              s2_sgn_q [3];
  logic [MW-1:0]     s2_mag_q [3];
  // stage 3: quotient magnitude, or the plain magnitude for measurements
  logic              s3_vld_q, s3_cal_q;
  logic              s3_sgn_q [3];
  logic [MW-1:0]     s3_q_q   [3];
  logic [tsac_pkg::PROD_W-1:0] prod [3];
  // stage 4: operands
  tsac_pkg::lane_t   roll_q, pitch_q;
  tsac_pkg::meta_t   meta_q;
  logic              dz, nzx, nzy;

  assign acc_x = in_data_i[15:0];
  assign acc_y = in_data_i[31:16];
  assign acc_z = in_data_i[47:32];

  assign accept  = in_vld_i && adv_i;
  assign is_cal  = (in_cmd_i == tsac_pkg::CMD_CAL);
  assign cnt_inc = cnt_q + tsac_pkg::CNT_W'(1);
  assign cal_fin = accept && is_cal
                   && (cnt_inc == tsac_pkg::CNT_W'(tsac_pkg::CAL_SAMPLES));

  assign nsx = sum_x_q - SW'(acc_x);
  assign nsy = sum_y_q - SW'(acc_y);
  assign nsz = sum_z_q - SW'(acc_z);

  always_comb begin
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    sum_z_d = sum_z_q;
    cnt_d   = cnt_q;
    if (cal_fin) begin
      sum_x_d = '0;
      sum_y_d = '0;
      sum_z_d = '0;
      cnt_d   = '0;
    end else if (accept && is_cal) begin
      sum_x_d = nsx;
      sum_y_d = nsy;
      sum_z_d = nsz;
      cnt_d   = cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      sum_z_q <= '0;
      cnt_q   <= '0;
    end else begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      sum_z_q <= sum_z_d;
      cnt_q   <= cnt_d;
    end
  end

  // valid bits of stages 1..3
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= accept && (!is_cal || cal_fin);
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign prod[a] = tsac_pkg::PROD_W'(s2_mag_q[a]) * tsac_pkg::PROD_W'(tsac_pkg::RECIP);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_cal_q   <= is_cal;
      s1_v_q[AX] <= is_cal ? nsx : SW'(acc_x);
      s1_v_q[AY] <= is_cal ? nsy : SW'(acc_y);
      s1_v_q[AZ] <= is_cal ? nsz : SW'(acc_z);
      s2_cal_q   <= s1_cal_q;
      s3_cal_q   <= s2_cal_q;
      for (int a = 0; a < 3; a++) begin
        s2_sgn_q[a] <= s1_v_q[a][SW-1];
        s2_mag_q[a] <= s1_v_q[a][SW-1] ? MW'(-s1_v_q[a]) : MW'(s1_v_q[a]);
        s3_sgn_q[a] <= s2_sgn_q[a];
        s3_q_q[a]   <= s2_cal_q ? MW'(prod[a] >> tsac_pkg::RECIP_SH) : s2_mag_q[a];
      end
    end
  end

  assign dz  = (s3_q_q[AZ] == '0);
  assign nzx = (s3_q_q[AX] == '0);
  assign nzy = (s3_q_q[AY] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else if (adv_i) begin
      meta_q.vld        <= s3_vld_q;
      meta_q.calfin     <= s3_cal_q;
      meta_q.roll.zero  <= nzy;
      meta_q.roll.full  <= dz && !nzy;
      meta_q.roll.neg   <= s3_sgn_q[AY];
      meta_q.pitch.zero <= nzx;
      meta_q.pitch.full <= dz && !nzx;
      meta_q.pitch.neg  <= s3_sgn_q[AX];
    end
  end

  // x = |den|, y = num * sign(den)
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      roll_q.x    <= CW'(s3_q_q[AZ]);
      roll_q.y    <= (s3_sgn_q[AY] ^ s3_sgn_q[AZ]) ? -CW'(s3_q_q[AY]) : CW'(s3_q_q[AY]);
      roll_q.ang  <= '0;
      pitch_q.x   <= CW'(s3_q_q[AZ]);
      pitch_q.y   <= (s3_sgn_q[AX] ^ s3_sgn_q[AZ]) ? -CW'(s3_q_q[AX]) : CW'(s3_q_q[AX]);
      pitch_q.ang <= '0;
    end
  end

  assign roll_o  = roll_q;
  assign pitch_o = pitch_q;
  assign meta_o  = meta_q;

  `TSAC_ASSERT_ALWAYS(a_cnt_range, cnt_q < tsac_pkg::CNT_W'(tsac_pkg::CAL_SAMPLES))
  `TSAC_ASSERT(a_cal_restart, cal_fin |=> (cnt_q == '0) && (sum_x_q == '0) && (sum_z_q == '0))

endmodule

// ----- hw/rtl/tilt_servo_angle_calibrated.sv -----
// Channel   | valid/ready                  | payload
// s_axis    | s_axis_tvalid/s_axis_tready  | tdata: acc_x, acc_y, acc_z; tuser: cmd
// m_axis    | m_axis_tvalid/m_axis_tready  | tdata: servo_roll, servo_pitch; tuser: calib_done
//
// One beat accepted per cycle while the pipe is not halted; a result passes 4 prep
// stages, the row of CORDIC cells, and the round and offset stages.
// Calibration samples that do not close the count make no result and leave a bubble.
// The whole pipe halts while a result sits unaccepted in the output register.
// Reset clears sums, count, offsets and all valid bits; no clearing pass.
// Depends on tsac_pkg, tsac_front, tsac_cordic_cell and the macros header.
`include "tilt_servo_angle_calibrated_macros.svh"
module tilt_servo_angle_calibrated (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] acc_x, [31:16] acc_y, [47:32] acc_z
  input  logic [0:0]  s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [16:0] servo_roll, [33:17] servo_pitch, zero fill
  output logic [0:0]  m_axis_tuser    // [0] calib_done
);

  localparam int NS = tsac_pkg::ATAN_STAGES;
  localparam int OW = tsac_pkg::OFF_W;
  localparam int UW = tsac_pkg::OUT_W;

  logic adv;
  tsac_pkg::lane_t front_roll, front_pitch;
  tsac_pkg::meta_t front_meta;
  tsac_pkg::lane_t roll_l  [NS];
  tsac_pkg::lane_t pitch_l [NS];
  tsac_pkg::meta_t meta_q  [NS];

  logic                 r_vld_q, r_cal_q;
  logic signed [OW-1:0] r_roll_q, r_pitch_q;
  logic signed [OW-1:0] roll_off_q, pitch_off_q;
  logic                 off_we;
  logic                 out_vld_q, out_done_q;
  logic signed [UW-1:0] out_roll_q, out_pitch_q, roll_srv, pitch_srv;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  tsac_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .in_vld_i  (s_axis_tvalid),
    .in_cmd_i  (s_axis_tuser[0]),
    .in_data_i (s_axis_tdata),
    .roll_o    (front_roll),
    .pitch_o   (front_pitch),
    .meta_o    (front_meta)
  );

  for (genvar k = 0; k < NS; k++) begin : g_cell
    if (k == 0) begin : g_first
      tsac_cordic_cell u_roll (
        .clk_i (clk_i), .en_i (adv), .idx_i (tsac_pkg::IDX_W'(k)),
        .lane_i (front_roll), .lane_o (roll_l[k])
      );
      tsac_cordic_cell u_pitch (
        .clk_i (clk_i), .en_i (adv), .idx_i (tsac_pkg::IDX_W'(k)),
        .lane_i (front_pitch), .lane_o (pitch_l[k])
      );
    end else begin : g_next
      tsac_cordic_cell u_roll (
        .clk_i (clk_i), .en_i (adv), .idx_i (tsac_pkg::IDX_W'(k)),
        .lane_i (roll_l[k-1]), .lane_o (roll_l[k])
      );
      tsac_cordic_cell u_pitch (
        .clk_i (clk_i), .en_i (adv), .idx_i (tsac_pkg::IDX_W'(k)),
        .lane_i (pitch_l[k-1]), .lane_o (pitch_l[k])
      );
    end
  end

  // side-band line alongside the cells
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        meta_q[k] <= '0;
      end
    end else if (adv) begin
      meta_q[0] <= front_meta;
      for (int k = 1; k < NS; k++) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  // round half up to 1/128 deg, clamp to +-90 deg, apply special cases
  function automatic logic signed [OW-1:0] fin_angle(
    input logic signed [tsac_pkg::ANG_W-1:0] ang,
    input tsac_pkg::frc_t                    f
  );
    logic signed [tsac_pkg::ANG_W-1:0] sum;
    logic signed [tsac_pkg::RND_W-1:0] rnd;
    logic signed [OW-1:0]              res;
    sum = ang + tsac_pkg::ANG_W'(2 ** (tsac_pkg::ANG_FRAC - 1));
    rnd = sum[tsac_pkg::ANG_W-1:tsac_pkg::ANG_FRAC];
    if (rnd > tsac_pkg::RND_W'(tsac_pkg::QUARTER_TURN)) begin
      res = OW'(tsac_pkg::QUARTER_TURN);
    end else if (rnd < -tsac_pkg::RND_W'(tsac_pkg::QUARTER_TURN)) begin
      res = -OW'(tsac_pkg::QUARTER_TURN);
    end else begin
      res = OW'(rnd);
    end
    if (f.zero) begin
      res = '0;
    end else if (f.full) begin
      res = f.neg ? -OW'(tsac_pkg::QUARTER_TURN) : OW'(tsac_pkg::QUARTER_TURN);
    end
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else if (adv) begin
      r_vld_q <= meta_q[NS-1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_cal_q   <= meta_q[NS-1].calfin;
      r_roll_q  <= fin_angle(roll_l[NS-1].ang, meta_q[NS-1].roll);
      r_pitch_q <= fin_angle(pitch_l[NS-1].ang, meta_q[NS-1].pitch);
    end
  end

  // servo = -angle + offset + 90 deg
  assign roll_srv  = -UW'(r_roll_q) + UW'(roll_off_q) + UW'(tsac_pkg::QUARTER_TURN);
  assign pitch_srv = -UW'(r_pitch_q) + UW'(pitch_off_q) + UW'(tsac_pkg::QUARTER_TURN);
  assign off_we    = adv && r_vld_q && r_cal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_off_q  <= '0;
      pitch_off_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (off_we) begin
        roll_off_q  <= r_roll_q;
        pitch_off_q <= r_pitch_q;
      end
      if (adv) begin
        out_vld_q <= r_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_done_q  <= r_cal_q;
      out_roll_q  <= r_cal_q ? UW'(tsac_pkg::QUARTER_TURN) : roll_srv;
      out_pitch_q <= r_cal_q ? UW'(tsac_pkg::QUARTER_TURN) : pitch_srv;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_pitch_q, out_roll_q};
  assign m_axis_tuser  = out_done_q;

  `TSAC_ASSERT(a_done_beat, m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[16:0] == UW'(tsac_pkg::QUARTER_TURN)) && (m_axis_tdata[33:17] == UW'(tsac_pkg::QUARTER_TURN)))
  `TSAC_ASSERT_ALWAYS(a_ready_when_empty, !out_vld_q |-> s_axis_tready)
  `TSAC_ASSERT(a_offset_hold, !off_we |=> $stable(roll_off_q) && $stable(pitch_off_q))

endmodule

// ----- tb/tilt_servo_angle_calibrated_tb.sv -----
// Self-checking testbench for tilt_servo_angle_calibrated: streams accelerometer beats,
// predicts the servo angles with its own CORDIC arctangent and checks every result beat.
// Depends on tsac_pkg and the block under test.
`timescale 1ns / 1ps
module tilt_servo_angle_calibrated_tb;
  import tsac_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int ITEMS          = 450;
  localparam int CALM_ITEMS     = 90;    // tail of the run with no idling
  localparam int HOLD_CYCLES    = 150;   // long receiver hold-off
  localparam int TAIL_CYCLES    = 40;    // pipe is 22 deep
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic signed [OUT_W-1:0] roll;
    logic signed [OUT_W-1:0] pitch;
    logic                    done;
  } servo_beat_t;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               known;   // expected angles typed in below
    logic signed [16:0] roll;
    logic signed [16:0] pitch;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // [15:0] acc_x, [31:16] acc_y, [47:32] acc_z
  logic [0:0]  s_axis_tuser = '0;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [16:0] servo_roll, [33:17] servo_pitch, zero fill
  logic [0:0]  m_axis_tuser;        // [0] calib_done

  tilt_servo_angle_calibrated u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // atan(2^-i) in 2^-16 degree
  longint atan_steps [TABLE_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  // Predictor state
  logic signed [SUM_W-1:0] tilt_sum_x = '0, tilt_sum_y = '0, tilt_sum_z = '0;
  logic [CNT_W-1:0]        cal_taken = '0;
  logic signed [OFF_W-1:0] roll_zero = '0, pitch_zero = '0;
  servo_beat_t             servo_expected_q[$];

  // Directed rows with typed-in angles override the prediction
  logic        use_typed = 1'b0;
  servo_beat_t typed_beat;

  bit calm = 1'b0;        // no idling on either side
  bit tx_steady = 1'b0;   // sender offers back to back
  bit hold_start = 1'b0;  // ask the receiver for its long hold-off

  int n_fed = 0, n_cal = 0, n_meas = 0, n_results = 0, n_closed = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  stim_row_t directed_rows [20] = '{
    '{CMD_MEAS, 16'sd0, 16'sd0, 16'sd0, 1'b1, 17'sd11520, 17'sd11520},
    '{CMD_MEAS, 16'sd0, 16'sd0, 16'sd1000, 1'b1, 17'sd11520, 17'sd11520},
    '{CMD_MEAS, -16'sd100, 16'sd100, 16'sd0, 1'b1, 17'sd0, 17'sd23040},
    '{CMD_MEAS, 16'sh7fff, 16'sh8000, 16'sd0, 1'b1, 17'sd23040, 17'sd0},
    '{CMD_MEAS, 16'sd1, -16'sd1, 16'sd0, 1'b1, 17'sd23040, 17'sd0},
    '{CMD_MEAS, 16'sd0, 16'sd0, 16'sh8000, 1'b1, 17'sd11520, 17'sd11520},
    '{CMD_MEAS, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 17'sd0, 17'sd0},
    '{CMD_MEAS, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 17'sd0, 17'sd0},
    '{CMD_MEAS, 16'sh7fff, 16'sh8000, 16'sd1, 1'b0, 17'sd0, 17'sd0},
    '{CMD_MEAS, 16'sh8000, 16'sh7fff, -16'sd1, 1'b0, 17'sd0, 17'sd0},
    '{CMD_MEAS, 16'sd1, -16'sd1, 16'sh7fff, 1'b0, 17'sd0, 17'sd0},
    '{CMD_MEAS, -16'sd1, 16'sd1, 16'sh8000, 1'b0, 17'sd0, 17'sd0},
    '{CMD_MEAS, 16'sd12000, -16'sd7000, 16'sd16384, 1'b0, 17'sd0, 17'sd0},
    '{CMD_MEAS, 16'sd0, 16'sd5, -16'sd3, 1'b0, 17'sd0, 17'sd0},
    '{CMD_CAL, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 17'sd0, 17'sd0},
    '{CMD_CAL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 17'sd0, 17'sd0},
    '{CMD_CAL, 16'sd0, 16'sd0, 16'sd16384, 1'b0, 17'sd0, 17'sd0},
    '{CMD_MEAS, 16'sd100, -16'sd200, 16'sd16000, 1'b0, 17'sd0, 17'sd0},
    '{CMD_CAL, 16'sd0, 16'sd0, 16'sd0, 1'b0, 17'sd0, 17'sd0},
    // offsets still zero while a calibration is open
    '{CMD_MEAS, 16'sd0, 16'sd0, 16'sd0, 1'b1, 17'sd11520, 17'sd11520}
  };

  // atan(num/den) in 1/128 degree, vectoring on (|den|, sign(den)*num)
  function automatic int tilt_atan_q7(longint num, longint den);
    longint x, y, ang, xn;
    int     i;
    if (den == 0) return num > 0 ? QUARTER_TURN : (num < 0 ? -QUARTER_TURN : 0);
    if (num == 0) return 0;
    x   = den < 0 ? -den : den;
    y   = den < 0 ? -num : num;
    ang = 0;
    for (i = 0; i < ATAN_STAGES && i < TABLE_LEN; i++) begin
      if (y >= 0) begin
        xn  = x + (y >>> i);
        y   = y - (x >>> i);
        ang = ang + atan_steps[i];
      end else begin
        xn  = x - (y >>> i);
        y   = y + (x >>> i);
        ang = ang - atan_steps[i];
      end
      x = xn;
    end
    ang = (ang + (64'sd1 <<< (ANG_FRAC - 1))) >>> ANG_FRAC;
    if (ang > QUARTER_TURN) ang = QUARTER_TURN;
    if (ang < -QUARTER_TURN) ang = -QUARTER_TURN;
    return int'(ang);
  endfunction

  function automatic void predict_servo(input logic cmd, input logic signed [15:0] ax,
                                        input logic signed [15:0] ay,
                                        input logic signed [15:0] az);
    servo_beat_t beat;
    longint      mx, my, mz;
    int          sr, sp;
    if (cmd == CMD_CAL) begin
      n_cal++;
      tilt_sum_x = tilt_sum_x - ax;
      tilt_sum_y = tilt_sum_y - ay;
      tilt_sum_z = tilt_sum_z - az;
      cal_taken  = cal_taken + 1'b1;
      if (cal_taken < CAL_SAMPLES) return;
      mx = longint'(tilt_sum_x) / CAL_SAMPLES;
      my = longint'(tilt_sum_y) / CAL_SAMPLES;
      mz = longint'(tilt_sum_z) / CAL_SAMPLES;
      roll_zero  = tilt_atan_q7(my, mz);
      pitch_zero = tilt_atan_q7(mx, mz);
      tilt_sum_x = '0;
      tilt_sum_y = '0;
      tilt_sum_z = '0;
      cal_taken  = '0;
      beat.roll  = OUT_W'(QUARTER_TURN);
      beat.pitch = OUT_W'(QUARTER_TURN);
      beat.done  = 1'b1;
    end else begin
      n_meas++;
      sr = QUARTER_TURN - tilt_atan_q7(ay, az) + int'(roll_zero);
      sp = QUARTER_TURN - tilt_atan_q7(ax, az) + int'(pitch_zero);
      beat.roll  = sr[OUT_W-1:0];
      beat.pitch = sp[OUT_W-1:0];
      beat.done  = 1'b0;
    end
    if (use_typed) beat = typed_beat;
    servo_expected_q.push_back(beat);
  endfunction

  // Both handshakes are stable between the falling edge and the next rising edge
  always @(negedge clk_i) begin
    servo_beat_t got, want;
    logic        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        predict_servo(s_axis_tuser[0], s_axis_tdata[15:0], s_axis_tdata[31:16],
                      s_axis_tdata[47:32]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        n_results++;
        got.roll  = m_axis_tdata[16:0];
        got.pitch = m_axis_tdata[33:17];
        got.done  = m_axis_tuser[0];
        if (got.done) n_closed++;
        if (servo_expected_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected beat roll %0d pitch %0d calib_done %0b", $time,
                   got.roll, got.pitch, got.done);
        end else begin
          want = servo_expected_q.pop_front();
          if (got.roll !== want.roll) begin
            mismatch_count++;
            $display("%0t: servo_roll expected %0d, got %0d", $time, want.roll, got.roll);
          end
          if (got.pitch !== want.pitch) begin
            mismatch_count++;
            $display("%0t: servo_pitch expected %0d, got %0d", $time, want.pitch,
                     got.pitch);
          end
          if (got.done !== want.done) begin
            mismatch_count++;
            $display("%0t: calib_done expected %0b, got %0b", $time, want.done, got.done);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, servo_expected_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Result sink: random stall bursts, quiet stretches, and one long hold-off on request
  initial begin
    int stall_left, quiet_left;
    stall_left = 0;
    quiet_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_start) begin
        hold_start = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && quiet_left > 0) begin
        quiet_left--;
      end else if (stall_left == 0 && !calm) begin
        case ($urandom_range(0, 15))
          0, 1:    stall_left = $urandom_range(1, 10);
          2:       quiet_left = $urandom_range(30, 150);
          default: ;
        endcase
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one sample beat and hold it until accepted; entered just after a rising edge
  task automatic feed_sample(input logic cmd, input logic signed [15:0] ax,
                             input logic signed [15:0] ay, input logic signed [15:0] az);
    logic fire;
    if (!calm && !tx_steady && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {az, ay, ax};
    s_axis_tuser  <= cmd;
    do begin
      @(negedge clk_i);
      fire = s_axis_tready;
      @(posedge clk_i);
    end while (!fire);
    n_fed++;
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (servo_expected_q.size() != 0);
  endtask

  function automatic logic signed [15:0] pick_axis();
    logic signed [15:0] v;
    case ($urandom_range(0, 9))
      0:       v = 16'sd0;
      1:       v = 16'sh8000;
      2:       v = 16'sh7fff;
      3:       v = -16'sd1;
      4:       v = 16'sd1;
      5, 6:    v = 16'($urandom_range(0, 255)) - 16'sd128;
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] jitter_axis(int base, int amp);
    int v;
    v = base + int'($urandom_range(0, 2 * amp));
    v = v - amp;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic measurement_burst(int count);
    int k;
    for (k = 0; k < count; k++) feed_sample(CMD_MEAS, pick_axis(), pick_axis(), pick_axis());
  endtask

  // Closes the open calibration, with a stray measurement now and then
  task automatic calibration_run();
    int bx, by, bz, amp, len, k;
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        bx = int'($urandom_range(0, 4000)) - 2000;
        by = int'($urandom_range(0, 4000)) - 2000;
        bz = int'($urandom_range(12000, 20000));
        if ($urandom_range(0, 1)) bz = -bz;
      end
      3: begin   // sums at their most positive
        bx = -32768; by = -32768; bz = -32768;
      end
      4: begin
        bx = 32767; by = 32767; bz = 32767;
      end
      default: begin
        bx = int'($urandom_range(0, 65535)) - 32768;
        by = int'($urandom_range(0, 65535)) - 32768;
        bz = int'($urandom_range(0, 65535)) - 32768;
      end
    endcase
    amp = $urandom_range(0, 400);
    len = CAL_SAMPLES - int'(cal_taken);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 11) == 0)
        feed_sample(CMD_MEAS, pick_axis(), pick_axis(), pick_axis());
      feed_sample(CMD_CAL, jitter_axis(bx, amp), jitter_axis(by, amp), jitter_axis(bz, amp));
    end
  endtask

  initial begin
    stim_row_t row;
    int        r, episode;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < $size(directed_rows); r++) begin
      row              = directed_rows[r];
      use_typed        = row.known;
      typed_beat.roll  = row.roll;
      typed_beat.pitch = row.pitch;
      typed_beat.done  = 1'b0;
      feed_sample(row.cmd, row.x, row.y, row.z);
      use_typed = 1'b0;
    end

    episode = 0;
    while (n_fed < ITEMS) begin
      if (n_fed >= ITEMS - CALM_ITEMS) calm = 1'b1;
      tx_steady = ($urandom_range(0, 3) == 0);
      if (episode == 0) begin
        calibration_run();
      end else if (episode == 1) begin
        // receiver holds off while the sender keeps offering: pipe fills and stalls
        hold_start = 1'b1;
        tx_steady  = 1'b1;
        measurement_burst(60);
      end else if (episode == 3) begin
        wait_all_results();
        measurement_burst($urandom_range(5, 25));
      end else begin
        case ($urandom_range(0, 5))
          0: calibration_run();
          1: begin   // calibration left open, then measured against old offsets
            repeat ($urandom_range(1, 15))
              feed_sample(CMD_CAL, pick_axis(), pick_axis(), pick_axis());
            measurement_burst($urandom_range(1, 8));
          end
          default: measurement_burst($urandom_range(5, 25));
        endcase
      end
      episode++;
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Fed %0d sample beats: %0d calibration, %0d measurement; %0d calibrations closed",
             n_fed, n_cal, n_meas, n_closed);
    $display("Checked %0d result beats against predicted servo angles, %0d mismatches",
             n_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
